FILE: rtl/indexed_list_store_defines.svh
// assertion macros for the indexed list store
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ILS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ILS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ILS_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define ILS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/ils_pkg.sv
package ils_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;

    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_DELETE = 3'd1,
        MODE_FIND   = 3'd2,
        MODE_GET    = 3'd3,
        MODE_UPDATE = 3'd4,
        MODE_CLEAR  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             upd;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] count;
    } cell_ctrl_t;

    // search result of the chain
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_pos;
    } find_res_t;

endpackage

FILE: rtl/ils_cell.sv
module ils_cell (
    input  logic                              clk,
    input  ils_pkg::cell_ctrl_t               ctrl,
    input  logic [ils_pkg::IDX_W-1:0]         idx,
    input  logic signed [ils_pkg::WORD_W-1:0] left_word,
    input  logic signed [ils_pkg::WORD_W-1:0] right_word,
    input  logic signed [ils_pkg::WORD_W-1:0] value,
    output logic signed [ils_pkg::WORD_W-1:0] word,
    output logic                              hit
);
    import ils_pkg::*;

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;
    logic                     at_pos;
    logic                     above_pos;
    logic                     in_use;

    assign at_pos    = (idx == ctrl.pos);
    assign above_pos = (idx > ctrl.pos);
    assign in_use    = ({1'b0, idx} < ctrl.count);

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.ins && above_pos)
        begin
            word_next = left_word;
        end
        else if ((ctrl.ins || ctrl.upd) && at_pos)
        begin
            word_next = value;
        end
        else if (ctrl.del && (above_pos || at_pos))
        begin
            word_next = right_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    assign hit  = in_use && (word_reg == value);

endmodule

FILE: rtl/ils_chain.sv
module ils_chain (
    input  logic                              clk,
    input  ils_pkg::cell_ctrl_t               ctrl,
    input  logic signed [ils_pkg::WORD_W-1:0] value,
    input  logic [ils_pkg::IDX_W-1:0]         rd_pos,
    output logic signed [ils_pkg::WORD_W-1:0] rd_word,
    output ils_pkg::find_res_t                find_res
);
    import ils_pkg::*;

    logic signed [WORD_W-1:0] words [CAPACITY];
    logic [CAPACITY-1:0]      hits;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [WORD_W-1:0] left_w;
        logic signed [WORD_W-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = words[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = words[g+1];
        end

        ils_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .idx        (IDX_W'(g)),
            .left_word  (left_w),
            .right_word (right_w),
            .value      (value),
            .word       (words[g]),
            .hit        (hits[g])
        );
    end

    // lowest matching cell wins
    always_comb
    begin
        find_res = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                find_res.hit     = 1'b1;
                find_res.hit_pos = IDX_W'(i);
            end
        end
    end

    assign rd_word = words[rd_pos];

endmodule

FILE: rtl/indexed_list_store.sv
// channel  handshake             words
// request  in_valid, in_stall    mode, position, value
// result   out_valid, out_stall  status, read_value, found, found_position, count, empty_res
//
// each request is first captured into the request word, then executed: the cell row
// (shift, write or compare) runs and loads the result register in a single pass
// reset clears the count and the handshake flags, cell contents are undefined
// until written
// a stalled result blocks the next execute cycle, one further request can be
// captured meanwhile
`include "indexed_list_store_defines.svh"

module indexed_list_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          mode,
    input  logic [6:0]                          position,
    input  logic signed [ils_pkg::WORD_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic signed [ils_pkg::WORD_W-1:0]   read_value,
    output logic                                found,
    output logic [ils_pkg::IDX_W-1:0]           found_position,
    output logic [ils_pkg::CNT_W-1:0]           count,
    output logic                                empty_res
);
    import ils_pkg::*;

    // captured request word
    logic                     busy_reg;
    mode_t                    mode_reg;
    logic [6:0]               pos_reg;
    logic signed [WORD_W-1:0] value_reg;

    // list length
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    // result register
    logic                     out_valid_reg;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [WORD_W-1:0] read_value_reg;
    logic signed [WORD_W-1:0] read_value_next;
    logic                     found_reg;
    logic                     found_next;
    logic [IDX_W-1:0]         found_pos_reg;
    logic [IDX_W-1:0]         found_pos_next;
    logic [CNT_W-1:0]         count_out_reg;

    logic                     accept;
    logic                     fire;
    logic                     pos_past_count;
    logic                     pos_at_or_past;
    cell_ctrl_t               ctrl;
    logic signed [WORD_W-1:0] rd_word;
    find_res_t                find_res;

    // a new word may be captured while an older result still waits
    assign in_stall = busy_reg;
    assign accept   = in_valid && !in_stall;
    // execute only when the result register can take the outcome
    assign fire     = busy_reg && (!out_valid_reg || !out_stall);

    // position compared at full width, the 7-bit count fits in it
    assign pos_past_count = (pos_reg > count_reg);
    assign pos_at_or_past = (pos_reg >= count_reg);

    always_comb
    begin
        status_next     = ST_OK;
        count_next      = count_reg;
        read_value_next = '0;
        found_next      = 1'b0;
        found_pos_next  = '0;
        ctrl            = '0;
        ctrl.pos        = pos_reg[IDX_W-1:0];
        ctrl.count      = count_reg;

        unique case (mode_reg)
            MODE_INSERT:
            begin
                if (pos_past_count)
                begin
                    status_next = ST_RANGE;
                end
                else if (count_reg == CNT_W'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.ins   = fire;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_DELETE:
            begin
                if (pos_at_or_past)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    ctrl.del   = fire;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            MODE_FIND:
            begin
                found_next     = find_res.hit;
                found_pos_next = find_res.hit_pos;
            end
            MODE_GET:
            begin
                if (pos_at_or_past)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    read_value_next = rd_word;
                end
            end
            MODE_UPDATE:
            begin
                if (pos_at_or_past)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    ctrl.upd = fire;
                end
            end
            MODE_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                // spare mode codes do nothing
            end
        endcase
    end

    ils_chain u_chain (
        .clk      (clk),
        .ctrl     (ctrl),
        .value    (value_reg),
        .rd_pos   (pos_reg[IDX_W-1:0]),
        .rd_word  (rd_word),
        .find_res (find_res)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (fire)
            begin
                busy_reg <= 1'b0;
            end

            if (fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode_t'(mode);
            pos_reg   <= position;
            value_reg <= value;
        end
        if (fire)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            found_reg      <= found_next;
            found_pos_reg  <= found_pos_next;
            count_out_reg  <= count_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign read_value     = read_value_reg;
    assign found          = found_reg;
    assign found_position = found_pos_reg;
    assign count          = count_out_reg;
    assign empty_res      = (count_out_reg == '0);

    // list never grows past its room
    `ILS_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    // a full status only comes from a full list
    `ILS_ASSERT_IMPL(a_full_count, clk, rst_n,
                     out_valid_reg && (status_reg == ST_FULL),
                     count_out_reg == CNT_W'(CAPACITY))
    // a captured word is always pending in the next cycle
    `ILS_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy_reg)
    // a find hit lies inside the list
    `ILS_ASSERT_IMPL(a_hit_inside, clk, rst_n,
                     out_valid_reg && found_reg,
                     {1'b0, found_pos_reg} < count_out_reg)

endmodule
